[sv/sliding_window_maximum_assert.svh]
// assertion macros for the rtl, included by swm_back
`ifndef SLIDING_WINDOW_MAXIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_ASSERT_SVH

`ifndef SYNTHESIS

// condition must hold at every rising clock edge outside reset
`define SWM_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SWM_ASSERT_ALWAYS(label, clk, rst, expr)
`define SWM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/swm_pkg.sv]
`timescale 1ns / 1ps

package swm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 7;
  localparam int WSIZE_W  = 7;

  // one input transaction as it travels through the queue
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       stream_start;
  } item_t;

  // one deque entry
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           pos;
  } entry_t;

endpackage

[sv/swm_ram.sv]
`timescale 1ns / 1ps

module swm_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write-first: a read of the address being written returns the new data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (we && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/swm_front.sv]
`timescale 1ns / 1ps

module swm_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  swm_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_ready,
  output swm_pkg::item_t q_item
);

  // two-entry queue between the input port and the deque engine
  swm_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

[sv/swm_back.sv]
`timescale 1ns / 1ps

module swm_back #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [swm_pkg::WSIZE_W-1:0]             window_size,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  swm_pkg::item_t                          q_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]     window_max,
  output logic [swm_pkg::POS_W-1:0]               window_end
);

  `include "sliding_window_maximum_assert.svh"

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int WCAP  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam int EW    = $bits(swm_pkg::entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FRONT = 2'd1;
  localparam logic [1:0] S_BACK  = 2'd2;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(WINDOW_MAX - 1) : p - 1'b1;
  endfunction

  logic [1:0]                          state, state_next;
  logic [PTR_W-1:0]                    front_pointer, front_pointer_next;
  logic [PTR_W-1:0]                    back_pointer, back_pointer_next;
  logic [CNT_W-1:0]                    entry_count, entry_count_next;
  logic [swm_pkg::POS_W-1:0]           position_counter, position_counter_next;
  logic [swm_pkg::WSIZE_W-1:0]         seen_count, seen_count_next;
  logic signed [swm_pkg::SAMPLE_W-1:0] cur_sample, cur_sample_next;
  logic [swm_pkg::POS_W-1:0]           cur_pos, cur_pos_next;
  logic                                out_valid_next;
  logic signed [swm_pkg::SAMPLE_W-1:0] window_max_next;
  logic [swm_pkg::POS_W-1:0]           window_end_next;

  logic [swm_pkg::WSIZE_W-1:0] eff_w;
  logic [swm_pkg::WSIZE_W-1:0] seen_sat;
  logic [swm_pkg::POS_W-1:0]   front_age;
  logic                        out_free;
  logic                        load;
  logic                        we;
  swm_pkg::entry_t             wr_entry;
  swm_pkg::entry_t             front_entry;
  swm_pkg::entry_t             back_entry;
  logic [EW-1:0]               front_raw;
  logic [EW-1:0]               back_raw;

  // effective window: zero reads as one, clamped to the deque depth and to at most 127
  always_comb begin
    if (window_size == '0) begin
      eff_w = swm_pkg::WSIZE_W'(1);
    end else if (window_size > swm_pkg::WSIZE_W'(WCAP)) begin
      eff_w = swm_pkg::WSIZE_W'(WCAP);
    end else begin
      eff_w = window_size;
    end
  end

  assign front_entry = swm_pkg::entry_t'(front_raw);
  assign back_entry  = swm_pkg::entry_t'(back_raw);
  assign front_age   = cur_pos - front_entry.pos;
  assign out_free    = !out_valid || out_ready;
  assign wr_entry    = '{value: cur_sample, pos: cur_pos};

  always_comb begin
    state_next            = state;
    front_pointer_next    = front_pointer;
    back_pointer_next     = back_pointer;
    entry_count_next      = entry_count;
    position_counter_next = position_counter;
    seen_count_next       = seen_count;
    cur_sample_next       = cur_sample;
    cur_pos_next          = cur_pos;
    out_valid_next        = out_valid && !out_ready;
    window_max_next       = window_max;
    window_end_next       = window_end;
    seen_sat              = (seen_count > eff_w) ? eff_w : seen_count;
    we                    = 1'b0;
    load                  = 1'b0;
    q_ready               = 1'b0;

    unique case (state)
      S_IDLE: begin
        load = q_valid;
      end
      S_FRONT: begin
        // drop entries that have left the window
        if ((entry_count != '0) && (front_age >= eff_w)) begin
          front_pointer_next = wrap_next(front_pointer);
          entry_count_next   = entry_count - 1'b1;
        end else begin
          state_next = S_BACK;
        end
      end
      S_BACK: begin
        // drop smaller entries at the back, then append
        if ((entry_count != '0) && (back_entry.value < cur_sample)) begin
          back_pointer_next = wrap_prev(back_pointer);
          entry_count_next  = entry_count - 1'b1;
        end else if (out_free) begin
          we                    = 1'b1;
          back_pointer_next     = wrap_next(back_pointer);
          entry_count_next      = entry_count + 1'b1;
          position_counter_next = cur_pos + 1'b1;
          seen_count_next       = (seen_sat < eff_w) ? seen_sat + 1'b1 : seen_sat;
          if (seen_count_next >= eff_w) begin
            out_valid_next  = 1'b1;
            window_max_next = (entry_count == '0) ? cur_sample : front_entry.value;
            window_end_next = cur_pos;
          end
          state_next = S_IDLE;
          load       = q_valid;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      q_ready         = 1'b1;
      state_next      = S_FRONT;
      cur_sample_next = q_item.sample;
      if (q_item.stream_start) begin
        front_pointer_next    = '0;
        back_pointer_next     = '0;
        entry_count_next      = '0;
        position_counter_next = '0;
        seen_count_next       = '0;
      end
      cur_pos_next = position_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      front_pointer    <= '0;
      back_pointer     <= '0;
      entry_count      <= '0;
      position_counter <= '0;
      seen_count       <= '0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      front_pointer    <= front_pointer_next;
      back_pointer     <= back_pointer_next;
      entry_count      <= entry_count_next;
      position_counter <= position_counter_next;
      seen_count       <= seen_count_next;
      out_valid        <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_sample <= cur_sample_next;
    cur_pos    <= cur_pos_next;
    window_max <= window_max_next;
    window_end <= window_end_next;
  end

  // two copies of the deque storage: one tracks the front, one the back
  swm_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_MAX)
  ) u_front_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (back_pointer),
    .wr_data (wr_entry),
    .rd_addr (front_pointer_next),
    .rd_data (front_raw)
  );

  swm_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_MAX)
  ) u_back_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (back_pointer),
    .wr_data (wr_entry),
    .rd_addr (wrap_prev(back_pointer_next)),
    .rd_data (back_raw)
  );

  `SWM_ASSERT_ALWAYS(a_count_bound, clk, rst, entry_count <= CNT_W'(WCAP))
  `SWM_ASSERT_ALWAYS(a_empty_ptrs, clk, rst,
                     (entry_count != '0) || (front_pointer == back_pointer))
  `SWM_ASSERT_NEXT(a_append_grows, clk, rst, we && !load,
                   (entry_count == $past(entry_count) + 1'b1) && (state == S_IDLE))
  `SWM_ASSERT_IMPLY(a_result_only_on_append, clk, rst,
                    out_valid_next && !(out_valid && !out_ready), we)

endmodule

[sv/sliding_window_maximum.sv]
`timescale 1ns / 1ps

// channel   direction  signals                                   transaction
// --------  ---------  ----------------------------------------  ---------------------
// in        input      in_valid, in_ready, sample, stream_start  one stream sample
// out       output     out_valid, out_ready, window_max,         one window maximum
//                      window_end
// cfg       input      cfg_valid, cfg_ready, cfg_data            window_size write
//
// a sample passes the front and then the back state of the deque engine, staying in each
// while it drops deque entries, set by the one-entry-per-cycle pop loop over the deque ram
// each sample is dropped at most once
// rst is synchronous; no clearing pass, the deque ram is only read between front and back
// a two-entry input queue and the output register let either side stall independently

module sliding_window_maximum #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // input samples
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                stream_start,
  // window results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0] window_max,
  output logic [swm_pkg::POS_W-1:0]           window_end,
  // window size register
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swm_pkg::WSIZE_W-1:0]         cfg_data
);

  logic [swm_pkg::WSIZE_W-1:0] window_size;
  swm_pkg::item_t              in_item;
  swm_pkg::item_t              q_item;
  logic                        q_valid;
  logic                        q_ready;

  // config writes are always taken; the registered value also applies to a sample in flight
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WSIZE_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      window_size <= cfg_data;
    end
  end

  assign in_item = '{sample: sample, stream_start: stream_start};

  // front: input queue that decouples the port from the deque engine
  swm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // back: monotonic deque engine with its own output register
  swm_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_max  (window_max),
    .window_end  (window_end)
  );

endmodule

[bench/sliding_window_maximum_test.sv]
`timescale 1ns / 1ps

module sliding_window_maximum_test;

  localparam int WINDOW_DEPTH = 64;
  // worst case for one sample: two queued samples, each with a full deque of pops,
  // plus the output register, with margin
  localparam int SETTLE_CYCLES = 2 * (WINDOW_DEPTH + 3) + 20;
  localparam int PHASE_ITEMS = 68;
  localparam int HOLD_OFF_CYCLES = 300;

  localparam logic signed [swm_pkg::SAMPLE_W-1:0] MOST_NEG = 16'sh8000;
  localparam logic signed [swm_pkg::SAMPLE_W-1:0] MOST_POS = 16'sh7fff;

  // one window maximum as the block should report it
  typedef struct packed {
    logic signed [swm_pkg::SAMPLE_W-1:0] peak;
    logic [swm_pkg::POS_W-1:0]           newest;
  } window_result_t;

  // kinds of sample runs in the random streams
  typedef enum int {
    RUN_UNIFORM,
    RUN_NARROW,
    RUN_RISING,
    RUN_FALLING,
    RUN_EXTREME
  } run_kind_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                stream_start = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [swm_pkg::SAMPLE_W-1:0] window_max;
  logic [swm_pkg::POS_W-1:0]           window_end;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [swm_pkg::WSIZE_W-1:0]         cfg_data = '0;

  sliding_window_maximum #(
    .WINDOW_MAX(WINDOW_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .stream_start(stream_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_max  (window_max),
    .window_end  (window_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the monotonic deque and its counters
  // ---------------------------------------------------------------------------
  logic [swm_pkg::WSIZE_W-1:0]         window_reg = 7'd4;
  logic signed [swm_pkg::SAMPLE_W-1:0] slot_value [WINDOW_DEPTH];
  logic [swm_pkg::POS_W-1:0]           slot_pos [WINDOW_DEPTH];
  logic [5:0]                          head = '0;
  logic [5:0]                          tail = '0;
  logic [6:0]                          fill = '0;
  logic [swm_pkg::POS_W-1:0]           next_pos = '0;
  logic [6:0]                          warm = '0;

  window_result_t expected_max_q[$];
  int error_count = 0;

  // idling controls, changed per phase by the tests
  int gap_max = 6;
  int stall_max = 6;
  // each request starts one long receiver hold-off
  int hold_requests = 0;

  // advance the deque by one sample; tells whether a window maximum comes out
  task automatic track_window_max(input logic signed [swm_pkg::SAMPLE_W-1:0] value,
                                  input logic start, output bit produced,
                                  output window_result_t res);
    logic [6:0]                span;
    logic [swm_pkg::POS_W-1:0] age;
    logic [5:0]                last;
    span = window_reg;
    // size zero means one, anything past the deque depth is clamped
    if (span == 7'd0) span = 7'd1;
    if (span > WINDOW_DEPTH) span = 7'(WINDOW_DEPTH);
    if (start) begin
      head = '0;
      tail = '0;
      fill = '0;
      next_pos = '0;
      warm = '0;
    end
    // retire entries that slid out of the window (age wraps at 128)
    while (fill != 0) begin
      age = next_pos - slot_pos[head];
      if (age < span) break;
      head = head + 6'd1;
      fill = fill - 7'd1;
    end
    // strictly smaller entries can never be a maximum again; equal ones stay
    while (fill != 0) begin
      last = tail - 6'd1;
      if (slot_value[last] >= value) break;
      tail = last;
      fill = fill - 7'd1;
    end
    if (fill >= WINDOW_DEPTH) begin
      head = head + 6'd1;
      fill = fill - 7'd1;
    end
    slot_value[tail] = value;
    slot_pos[tail] = next_pos;
    tail = tail + 6'd1;
    fill = fill + 7'd1;
    res.newest = next_pos;
    next_pos = next_pos + 1'b1;
    // a shrunk window also shortens the warm-up count
    if (warm > span) warm = span;
    if (warm < span) warm = warm + 7'd1;
    produced = (warm >= span);
    res.peak = slot_value[head];
  endtask

  // ---------------------------------------------------------------------------
  // sender side: entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [swm_pkg::SAMPLE_W-1:0] value,
                             input logic start);
    int gap;
    bit produced;
    window_result_t res;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    stream_start <= start;
    do @(posedge clk); while (in_ready !== 1'b1);
    track_window_max(value, start, produced, res);
    if (produced) expected_max_q.insert(expected_max_q.size(), res);
    @(negedge clk);
  endtask

  // pause the sender until every pending maximum has arrived and the engine has
  // had time to finish samples that produce nothing
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_max_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // window size write, only ever issued with the block idle
  task automatic write_window(input logic [swm_pkg::WSIZE_W-1:0] size);
    cfg_valid <= 1'b1;
    cfg_data <= size;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    window_reg = size;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: out_ready changes at the falling edge only
  // ---------------------------------------------------------------------------
  initial begin
    int ready_wait;
    int hold_left;
    int holds_served;
    bit accepted;
    ready_wait = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      accepted = (out_valid === 1'b1) && (out_ready === 1'b1);
      @(negedge clk);
      if (accepted) begin
        ready_wait = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
      end
      if (hold_requests != holds_served) begin
        hold_left = HOLD_OFF_CYCLES;
        holds_served = hold_requests;
      end
      if (hold_left > 0) begin
        // long hold-off so the block backs up into its input
        out_ready <= 1'b0;
        hold_left--;
      end else if (ready_wait > 0) begin
        out_ready <= 1'b0;
        ready_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker: every accepted transaction against the oldest expectation
  always @(posedge clk) begin
    window_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_max_q.size() == 0) begin
        $error("unexpected result: window_max %0d window_end %0d", window_max, window_end);
        error_count++;
      end else begin
        want = expected_max_q[0];
        expected_max_q.delete(0);
        if (window_max !== want.peak) begin
          $error("window_max mismatch: expected %0d, actual %0d", want.peak, window_max);
          error_count++;
        end
        if (window_end !== want.newest) begin
          $error("window_end mismatch: expected %0d, actual %0d", want.newest, window_end);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset size of four, extremes, equal values, restart mid-stream
  task automatic test_reset_window();
    send_sample(MOST_POS, 1'b0);
    send_sample(MOST_NEG, 1'b0);
    send_sample(MOST_NEG, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(MOST_NEG, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd7, 1'b1);
    wait_for_results();
  endtask

  // size one, size zero (behaves as one), size two with equal values
  task automatic test_tiny_windows();
    write_window(7'd1);
    send_sample(16'sd5, 1'b0);
    send_sample(MOST_NEG, 1'b1);
    send_sample(MOST_POS, 1'b0);
    wait_for_results();
    write_window(7'd0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    wait_for_results();
    write_window(7'd2);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd2, 1'b0);
    wait_for_results();
  endtask

  // a descending run fills the deque, then the window shrinks without a restart
  task automatic test_shrink_mid_stream();
    write_window(7'd8);
    for (int k = 0; k < 8; k++) send_sample(16'(70 - 10 * k), (k == 0));
    wait_for_results();
    write_window(7'd3);
    send_sample(-16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b0);
    wait_for_results();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering samples
  task automatic test_full_backpressure();
    write_window(7'd1);
    gap_max = 0;
    stall_max = 0;
    hold_requests++;
    for (int k = 0; k < 40; k++) send_sample(16'($urandom), 1'b0);
    wait_for_results();
  endtask

  // sender stops until everything is back, then carries on in the same stream
  task automatic test_sender_pause();
    write_window(7'd5);
    gap_max = 6;
    stall_max = 6;
    for (int k = 0; k < 20; k++) send_sample(16'($urandom), (k == 0));
    in_valid <= 1'b0;
    while (expected_max_q.size() != 0) @(negedge clk);
    for (int k = 0; k < 20; k++) send_sample(16'($urandom), 1'b0);
    wait_for_results();
  endtask

  // one phase of a random stream: runs of uniform, narrow, monotonic or extreme
  // samples, so the deque both grows long and collapses in big pops
  task automatic run_stream_phase(input logic [swm_pkg::WSIZE_W-1:0] size);
    run_kind_t kind;
    int run_left;
    logic signed [swm_pkg::SAMPLE_W-1:0] value;
    logic [swm_pkg::SAMPLE_W-1:0] step;
    logic start;
    write_window(size);
    // idle on both sides at random, with some phases fully back to back
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
    run_left = 0;
    kind = RUN_UNIFORM;
    value = '0;
    step = '0;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (run_left == 0) begin
        kind = run_kind_t'($urandom_range(0, 4));
        run_left = $urandom_range(1, 40);
        value = 16'($urandom);
        step = 16'($urandom_range(1, 300));
      end
      case (kind)
        RUN_UNIFORM: value = 16'($urandom);
        RUN_NARROW:  value = 16'($urandom_range(0, 6)) - 16'sd3;
        RUN_RISING:  value = value + step;
        RUN_FALLING: value = value - step;
        default: begin
          case ($urandom_range(0, 3))
            0: value = MOST_NEG;
            1: value = MOST_POS;
            2: value = 16'sd0;
            default: value = -16'sd1;
          endcase
        end
      endcase
      run_left--;
      // half the phases restart the stream; the rest keep it and resize it
      if (k == 0) start = 1'($urandom_range(0, 1));
      else start = ($urandom_range(0, 99) == 0);
      send_sample(value, start);
    end
    wait_for_results();
  endtask

  task automatic test_random_streams();
    logic [swm_pkg::WSIZE_W-1:0] sizes [20];
    sizes = '{7'd64, 7'd127, 7'd65, 7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16,
              7'd31, 7'd32, 7'd33, 7'd63, 7'd4, 7'd100, 7'd7, 7'd64, 7'd0, 7'd0};
    // the last two sizes are drawn at random, the last one from 1 to 12
    sizes[18] = 7'($urandom_range(0, 127));
    sizes[19] = 7'($urandom_range(1, 12));
    foreach (sizes[n]) run_stream_phase(sizes[n]);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_window();
    test_tiny_windows();
    test_shrink_mid_stream();
    test_full_backpressure();
    test_sender_pause();
    test_random_streams();
    wait_for_results();
    if (expected_max_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_max_q.size());
    end
    if (error_count == 0 && expected_max_q.size() == 0) begin
      $display("sliding_window_maximum_test passed");
    end else begin
      $display("sliding_window_maximum_test failed");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("sliding_window_maximum_test failed");
    $finish;
  end

endmodule
